// ===== rtl/range_scan_to_grid_cell_defines.svh =====
// Assertion macros for the scan-to-grid block.
`ifndef RANGE_SCAN_TO_GRID_CELL_DEFINES_SVH
`define RANGE_SCAN_TO_GRID_CELL_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Condition must hold in the same cycle as the trigger
`define RSG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsg assertion failed");
// Condition must hold in the cycle after the trigger
`define RSG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsg assertion failed");
`else
`define RSG_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define RSG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/rsg_pkg.sv =====
package rsg_pkg;

  // Field widths
  localparam int ANG_W  = 16;
  localparam int DIST_W = 14;
  localparam int OUT_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Grid geometry
  localparam int MAP_SIZE    = 1024;
  localparam int CENTER_X    = 500;
  localparam int CENTER_Y    = 130;
  localparam int ROW_MARGIN  = 30;
  localparam int RANGE_GUARD = 10;

  // Rotation datapath
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int DW      = 34;
  localparam int ZW      = 18;
  localparam int CELL_W  = DW - FRAC_BITS;
  localparam int GAIN_W  = 17;
  localparam int PROD_W  = DIST_W + 1 + GAIN_W;
  localparam logic signed [GAIN_W-1:0] INV_GAIN  = 17'sd39797;
  localparam logic signed [ZW-1:0]     HALF_TURN = ZW'(32768);
  localparam logic signed [DW-1:0]     OFF_X = DW'(CENTER_X) <<< FRAC_BITS;
  localparam logic signed [DW-1:0]     OFF_Y = DW'(CENTER_Y) <<< FRAC_BITS;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Register reset values
  localparam logic [ANG_W-1:0]  START_ANGLE_RST = 16'h8000;
  localparam logic [ANG_W-1:0]  ANGLE_STEP_RST  = 16'h0000;
  localparam logic [DIST_W-1:0] MIN_RANGE_RST   = 14'd0;
  localparam logic [DIST_W-1:0] MAX_RANGE_RST   = 14'd16383;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ANGLE = 2'd0,
    REG_ANGLE_STEP  = 2'd1,
    REG_MIN_RANGE   = 2'd2,
    REG_MAX_RANGE   = 2'd3
  } cfg_reg_t;

  // Counted sample handed from front to back
  typedef struct packed {
    logic [ANG_W-1:0]  angle;
    logic [DIST_W-1:0] distance;
  } item_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  // Arctangent of 2^-k in binary angle units
  function automatic logic signed [ZW-1:0] atan_unit(input logic [3:0] k);
    logic signed [ZW-1:0] a;
    case (k)
      4'd0:  a = 18'sd8192;
      4'd1:  a = 18'sd4836;
      4'd2:  a = 18'sd2555;
      4'd3:  a = 18'sd1297;
      4'd4:  a = 18'sd651;
      4'd5:  a = 18'sd326;
      4'd6:  a = 18'sd163;
      4'd7:  a = 18'sd81;
      4'd8:  a = 18'sd41;
      4'd9:  a = 18'sd20;
      4'd10: a = 18'sd10;
      4'd11: a = 18'sd5;
      4'd12: a = 18'sd3;
      4'd13: a = 18'sd1;
      4'd14: a = 18'sd1;
      default: a = 18'sd0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/rsg_ifs.sv =====
interface rsg_scan_if;
  import rsg_pkg::*;
  logic              valid;
  logic              ready;
  logic              scan_start;
  logic [DIST_W-1:0] distance;
  modport source (output valid, scan_start, distance, input ready);
  modport sink   (input valid, scan_start, distance, output ready);
endinterface

interface rsg_grid_if;
  import rsg_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] column;
  logic [OUT_W-1:0] row;
  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface

interface rsg_cfg_if;
  import rsg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/range_scan_to_grid_cell.sv =====
// Path: a counted sample reaches the output through the queue write on its input edge,
//   the scaling stage, 16 rotation stages and the output register.
// Throughput: one sample per cycle while the grid side is not stalling; the pipelined
//   rotation sets that rate and a 4-entry queue lets input and output stall on their own.
// Reset (rst, synchronous): clears queue, pipeline valids, output and beam angle;
//   registers return to start_angle -32768, step 0, min 0, max 16383.
`include "range_scan_to_grid_cell_defines.svh"

module range_scan_to_grid_cell (
  input  logic       clk,
  input  logic       rst,
  rsg_cfg_if.sink    cfg,
  rsg_scan_if.sink   scan,
  rsg_grid_if.source grid
);
  import rsg_pkg::*;

  logic   push;
  item_t  push_item;
  logic   pop;
  item_t  head;
  qstat_t qstat;

  // Take beats, track angle, drop out-of-range samples
  rsg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .scan      (scan),
    .q_full    (qstat.full),
    .push      (push),
    .push_item (push_item)
  );

  // Buffer counted samples
  rsg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  // Rotate, offset and place on the grid
  rsg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!qstat.empty),
    .pop        (pop),
    .grid       (grid)
  );

  `RSG_ASSERT_NOW(a_no_overflow, clk, rst, push, !qstat.full)
  `RSG_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, !qstat.empty)
  `RSG_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, qstat.count == $past(qstat.count) + 1'b1)
  `RSG_ASSERT_NOW(a_stall_holds, clk, rst, grid.valid && !grid.ready, !pop)

endmodule

// ===== rtl/rsg_front.sv =====
module rsg_front (
  input  logic           clk,
  input  logic           rst,
  rsg_cfg_if.sink        cfg,
  rsg_scan_if.sink       scan,
  input  logic           q_full,
  output logic           push,
  output rsg_pkg::item_t push_item
);
  import rsg_pkg::*;

  logic [ANG_W-1:0]  start_angle;
  logic [ANG_W-1:0]  angle_step;
  logic [DIST_W-1:0] min_range;
  logic [DIST_W-1:0] max_range;
  logic [ANG_W-1:0]  beam_angle;
  logic [ANG_W-1:0]  angle_now;
  logic              accept;
  logic              counted;

  assign cfg.ready  = 1'b1;
  assign scan.ready = !q_full;
  assign accept     = scan.valid && scan.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle <= START_ANGLE_RST;
      angle_step  <= ANGLE_STEP_RST;
      min_range   <= MIN_RANGE_RST;
      max_range   <= MAX_RANGE_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_START_ANGLE: start_angle <= cfg.data;
        REG_ANGLE_STEP:  angle_step  <= cfg.data;
        REG_MIN_RANGE:   min_range   <= cfg.data[DIST_W-1:0];
        REG_MAX_RANGE:   max_range   <= cfg.data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Restart the angle on a new scan, then advance it every beat
  assign angle_now = scan.scan_start ? start_angle : beam_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_angle <= '0;
    end else if (accept) begin
      beam_angle <= angle_now + angle_step;
    end
  end

  // Keep only samples strictly inside the range window
  assign counted = (scan.distance > min_range) &&
                   (({1'b0, scan.distance} + (DIST_W+1)'(RANGE_GUARD)) <
                    {1'b0, max_range});

  assign push               = accept && counted;
  assign push_item.angle    = angle_now;
  assign push_item.distance = scan.distance;

endmodule

// ===== rtl/rsg_queue.sv =====
module rsg_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rsg_pkg::item_t  push_item,
  input  logic            pop,
  output rsg_pkg::item_t  head,
  output rsg_pkg::qstat_t stat
);
  import rsg_pkg::*;

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // Store incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head       = mem[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);

endmodule

// ===== rtl/rsg_back.sv =====
module rsg_back (
  input  logic           clk,
  input  logic           rst,
  input  rsg_pkg::item_t head,
  input  logic           head_valid,
  output logic           pop,
  rsg_grid_if.source     grid
);
  import rsg_pkg::*;

  logic                  adv;
  logic [CORDIC_STEPS:0] sv;
  logic signed [DW-1:0]  sx [CORDIC_STEPS+1];
  logic signed [DW-1:0]  sy [CORDIC_STEPS+1];
  logic signed [ZW-1:0]  sz [CORDIC_STEPS+1];

  logic signed [ANG_W-1:0]  a_s;
  logic signed [ZW-1:0]     z_ext;
  logic signed [ZW-1:0]     z0_next;
  logic                     fold;
  logic signed [DIST_W:0]   d_s;
  logic signed [PROD_W-1:0] prod;

  logic signed [DW-1:0] xo;
  logic signed [DW-1:0] yo;
  logic                 x_ok;
  logic                 y_ok;
  logic [CELL_W-1:0]    cx;
  logic [CELL_W-1:0]    cy;
  logic [CELL_W-1:0]    row_full;
  logic                 hit;

  logic             out_valid;
  logic [OUT_W-1:0] out_column;
  logic [OUT_W-1:0] out_row;

  // Whole pipeline moves unless the output beat is stuck
  assign adv = !out_valid || grid.ready;
  assign pop = adv && head_valid;

  // Fold the angle into a half turn and scale the start vector
  always_comb begin
    a_s   = $signed(head.angle);
    z_ext = ZW'(a_s);
    fold  = 1'b0;
    if (a_s > 16'sd16384) begin
      z0_next = z_ext - HALF_TURN;
      fold    = 1'b1;
    end else if (a_s < -16'sd16384) begin
      z0_next = z_ext + HALF_TURN;
      fold    = 1'b1;
    end else begin
      z0_next = z_ext;
    end
    d_s  = fold ? -$signed({1'b0, head.distance}) : $signed({1'b0, head.distance});
    prod = d_s * INV_GAIN;
  end

  // Entry stage and one rotation step per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (adv) begin
      sv <= {sv[CORDIC_STEPS-1:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx[0] <= '0;
      sy[0] <= DW'(prod);
      sz[0] <= z0_next;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        if (!sz[k][ZW-1]) begin
          sx[k+1] <= sx[k] - (sy[k] >>> k);
          sy[k+1] <= sy[k] + (sx[k] >>> k);
          sz[k+1] <= sz[k] - atan_unit(4'(k));
        end else begin
          sx[k+1] <= sx[k] + (sy[k] >>> k);
          sy[k+1] <= sy[k] - (sx[k] >>> k);
          sz[k+1] <= sz[k] + atan_unit(4'(k));
        end
      end
    end
  end

  // Offset to grid origin, truncate to cells and bound-check
  always_comb begin
    xo   = sx[CORDIC_STEPS] + OFF_X;
    yo   = sy[CORDIC_STEPS] + OFF_Y;
    x_ok = !xo[DW-1] || ((&xo[DW-1:FRAC_BITS]) && (|xo[FRAC_BITS-1:0]));
    y_ok = !yo[DW-1] || ((&yo[DW-1:FRAC_BITS]) && (|yo[FRAC_BITS-1:0]));
    cx   = xo[DW-1] ? '0 : xo[DW-1:FRAC_BITS];
    cy   = yo[DW-1] ? '0 : yo[DW-1:FRAC_BITS];
    hit  = x_ok && y_ok && (cx < CELL_W'(MAP_SIZE)) &&
           (cy < CELL_W'(MAP_SIZE - ROW_MARGIN));
    row_full = CELL_W'(MAP_SIZE - ROW_MARGIN - 1) - cy;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sv[CORDIC_STEPS] && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_column <= cx[OUT_W-1:0];
      out_row    <= row_full[OUT_W-1:0];
    end
  end

  assign grid.valid  = out_valid;
  assign grid.column = out_column;
  assign grid.row    = out_row;

endmodule

// ===== sim/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsg_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 30;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 9;

  // Expected grid hits: mirrors the register file and the beam angle, rotates each
  // counted sample with a 16-step CORDIC and queues the hit it lands on.
  class grid_hit_tracker;
    typedef struct {
      logic [OUT_W-1:0] column;
      logic [OUT_W-1:0] row;
    } grid_hit_t;

    grid_hit_t pending_hits[$];
    logic [ANG_W-1:0]  start_angle;
    logic [ANG_W-1:0]  angle_step;
    logic [DIST_W-1:0] min_range;
    logic [DIST_W-1:0] max_range;
    logic [ANG_W-1:0]  beam_angle;
    int errors;
    int turn_step[CORDIC_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                    41, 20, 10, 5, 3, 1, 1, 0};

    function new();
      start_angle = 16'h8000;
      angle_step  = '0;
      min_range   = '0;
      max_range   = 14'd16383;
      beam_angle  = '0;
      errors      = 0;
    endfunction

    // Register bits above the field width are dropped
    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_START_ANGLE: start_angle = value;
        REG_ANGLE_STEP:  angle_step  = value;
        REG_MIN_RANGE:   min_range   = value[DIST_W-1:0];
        REG_MAX_RANGE:   max_range   = value[DIST_W-1:0];
        default: ;
      endcase
    endfunction

    // Truncate toward zero; a value just below zero still lands in cell 0
    function bit to_grid(longint v, output longint idx);
      idx = 0;
      if (v >= 0) begin
        idx = v >>> FRAC_BITS;
        return 1;
      end
      if (v > -(longint'(1) <<< FRAC_BITS)) return 1;
      return 0;
    endfunction

    function void note_sample(logic scan_start, logic [DIST_W-1:0] distance);
      logic [ANG_W-1:0] angle_now;
      int z;
      int k;
      longint vx, vy, nx, ny, cx, cy;
      grid_hit_t hit;
      // Restart on the first beam of a scan, then advance whether counted or not
      if (scan_start) beam_angle = start_angle;
      angle_now  = beam_angle;
      beam_angle = beam_angle + angle_step;
      if (int'(distance) <= int'(min_range) ||
          int'(distance) >= int'(max_range) - RANGE_GUARD) return;
      z  = int'($signed(angle_now));
      vx = 0;
      vy = longint'(distance) * 39797;
      // Fold into the half plane the rotation converges on
      if (z > 16384) begin
        z  = z - 32768;
        vy = -vy;
      end else if (z < -16384) begin
        z  = z + 32768;
        vy = -vy;
      end
      for (k = 0; k < CORDIC_STEPS; k++) begin
        if (z >= 0) begin
          nx = vx - (vy >>> k);
          ny = vy + (vx >>> k);
          z  = z - turn_step[k];
        end else begin
          nx = vx + (vy >>> k);
          ny = vy - (vx >>> k);
          z  = z + turn_step[k];
        end
        vx = nx;
        vy = ny;
      end
      vx = vx + (longint'(CENTER_X) <<< FRAC_BITS);
      vy = vy + (longint'(CENTER_Y) <<< FRAC_BITS);
      // Drop points off the grid or in the bottom margin
      if (!to_grid(vx, cx) || !to_grid(vy, cy)) return;
      if (cx >= MAP_SIZE || cy >= MAP_SIZE - ROW_MARGIN) return;
      hit.column = cx[OUT_W-1:0];
      hit.row    = OUT_W'(MAP_SIZE - ROW_MARGIN - 1 - cy);
      pending_hits.push_back(hit);
    endfunction

    function void check_hit(logic [OUT_W-1:0] column, logic [OUT_W-1:0] row);
      grid_hit_t want;
      if (pending_hits.size() == 0) begin
        $error("unexpected grid beat: column %0d row %0d", column, row);
        errors++;
        return;
      end
      want = pending_hits.pop_front();
      if (column !== want.column) begin
        $error("column: expected %0d, actual %0d", want.column, column);
        errors++;
      end
      if (row !== want.row) begin
        $error("row: expected %0d, actual %0d", want.row, row);
        errors++;
      end
    endfunction

    function int pending();
      return pending_hits.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  rsg_scan_if scan ();
  rsg_grid_if grid ();
  rsg_cfg_if  cfg ();

  range_scan_to_grid_cell u_dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .scan (scan),
    .grid (grid)
  );

  grid_hit_tracker sb = new();

  int send_idle_pct = 31;
  int recv_idle_pct = 83;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int cycle_cnt = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Give up on a hung run
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // Grid side: check each accepted beat, stall at random or for a long hold-off
  initial begin
    grid.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && grid.valid && grid.ready) sb.check_hit(grid.column, grid.row);
      if (hold_req) begin
        hold_cnt = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        grid.ready <= 1'b0;
      end else begin
        grid.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one sample, with random gaps in front, and note it once accepted
  task send_sample(input logic start_bit, input logic [DIST_W-1:0] sample_dist);
    while ($urandom_range(99) < send_idle_pct) begin
      scan.valid <= 1'b0;
      @(posedge clk);
    end
    scan.valid      <= 1'b1;
    scan.scan_start <= start_bit;
    scan.distance   <= sample_dist;
    do @(posedge clk); while (!scan.ready);
    sb.note_sample(start_bit, sample_dist);
  endtask

  task write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    sb.set_reg(idx, value);
  endtask

  // Write all four registers; junk goes into the unused top bits of the ranges
  task load_regs(input logic [ANG_W-1:0] start_val, input logic [ANG_W-1:0] step_val,
                 input logic [DIST_W-1:0] min_val, input logic [DIST_W-1:0] max_val);
    write_reg(REG_START_ANGLE, start_val);
    write_reg(REG_ANGLE_STEP, step_val);
    write_reg(REG_MIN_RANGE, {2'($urandom), min_val});
    write_reg(REG_MAX_RANGE, {2'($urandom), max_val});
    cfg.valid <= 1'b0;
  endtask

  // Stop offering, drain expected hits, then let rejected samples clear the pipe
  task settle();
    scan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Mostly plottable ranges, some on the range limits, some anywhere
  function logic [DIST_W-1:0] pick_distance();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 70) v = $urandom_range(1000);
    else if (r < 80) v = int'(sb.min_range) + $urandom_range(2) - 1;
    else if (r < 90) v = int'(sb.max_range) - RANGE_GUARD + $urandom_range(2) - 1;
    else v = $urandom_range(16383);
    if (v < 0) v = 0;
    if (v > 16383) v = 16383;
    return DIST_W'(v);
  endfunction

  // Scans of random length with random ranges; a few stray scan-start flags
  task run_scans(input int count);
    int left;
    int len;
    int i;
    logic start_bit;
    left = count;
    while (left > 0) begin
      len = $urandom_range(60, 4);
      for (i = 0; i < len && left > 0; i++) begin
        start_bit = (i == 0);
        if ($urandom_range(99) < 8) start_bit = 1'($urandom_range(1));
        send_sample(start_bit, pick_distance());
        left--;
      end
    end
  endtask

  initial begin
    int ph;
    int i;
    logic [ANG_W-1:0] step_val;
    logic [DIST_W-1:0] max_val;
    rst             <= 1'b1;
    scan.valid      <= 1'b0;
    scan.scan_start <= 1'b0;
    scan.distance   <= '0;
    cfg.valid       <= 1'b0;
    cfg.index       <= REG_START_ANGLE;
    cfg.data        <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: first beam uses the reset angle of zero, then the half turn
    send_sample(1'b0, 14'd200);
    send_sample(1'b1, 14'd0);
    send_sample(1'b0, 14'd1);
    send_sample(1'b0, 14'd130);
    send_sample(1'b0, 14'd131);
    send_sample(1'b0, 14'd16372);
    send_sample(1'b0, 14'd16373);
    send_sample(1'b0, 14'd16383);
    settle();

    // Quarter turn exactly and just past it; range limits on both ends
    load_regs(16'h4000, 16'h0001, 14'd50, 14'd700);
    send_sample(1'b1, 14'd300);
    send_sample(1'b0, 14'd300);
    send_sample(1'b0, 14'd50);
    send_sample(1'b0, 14'd51);
    send_sample(1'b0, 14'd689);
    send_sample(1'b0, 14'd690);
    settle();

    // Sweep a full turn in eighths so the angle wraps
    load_regs(16'hC000, 16'h2000, 14'd0, 14'd1023);
    send_sample(1'b1, 14'd480);
    for (i = 0; i < 8; i++) send_sample(1'b0, 14'd480);
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph / 3)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // Extreme settings on some phases, random ones on the rest
      if (ph == 1) begin
        load_regs(16'h7FFF, 16'h8000, 14'd0, 14'd16383);
      end else if (ph == 4) begin
        load_regs(16'h0000, 16'h7FFF, 14'd16383, 14'd0);
      end else if (ph == 7) begin
        load_regs(16'($urandom), 16'($urandom), 14'd0, 14'd9);
      end else begin
        if ($urandom_range(99) < 50) step_val = 16'($urandom_range(1200) - 600);
        else step_val = 16'($urandom);
        if ($urandom_range(99) < 80) max_val = 14'($urandom_range(1300, 300));
        else max_val = 14'd16383;
        load_regs(16'($urandom), step_val, 14'($urandom_range(150)), max_val);
      end
      // Hold the grid side off so the block backs up into the scan side
      if (ph == 2 || ph == 6) hold_req = 1'b1;
      if (ph == 4 || ph == 7) run_scans(40);
      else run_scans(140);
      settle();
    end

    repeat (SETTLE_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
